// ----- hdl/swz_pkg.sv -----
// Shared constants, register codes and clamp helpers for the workgroup swizzle block.
package swz_pkg;

    localparam int CHIPLETS   = 8;
    localparam int GROUP_W    = 20;
    localparam int HEAD_CNT_W = 9;
    localparam int BLOCKS_W   = 13;
    localparam int BLOCK_W    = 12;
    localparam int SHEAD_W    = 8;
    localparam int CHIP_OUT_W = 3;
    localparam int HEADS_MAX  = 256;
    localparam int BLOCKS_MAX = 4096;
    localparam int HEADS_RST  = 8;
    localparam int BLOCKS_RST = 4;
    localparam int DIV_STEPS  = 4;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    typedef enum logic [0:0] {
        REG_HEAD_COUNT     = 1'b0,
        REG_BLOCKS_IN_HEAD = 1'b1
    } swz_reg_t;

    function automatic logic [HEAD_CNT_W-1:0] clamp_heads(input logic [HEAD_CNT_W-1:0] v);
        logic [HEAD_CNT_W-1:0] r;
        if (v == '0)
            r = HEAD_CNT_W'(1);
        else if (v > HEAD_CNT_W'(HEADS_MAX))
            r = HEAD_CNT_W'(HEADS_MAX);
        else
            r = v;
        return r;
    endfunction

    function automatic logic [BLOCKS_W-1:0] clamp_blocks(input logic [BLOCKS_W-1:0] v);
        logic [BLOCKS_W-1:0] r;
        if (v == '0)
            r = BLOCKS_W'(1);
        else if (v > BLOCKS_W'(BLOCKS_MAX))
            r = BLOCKS_W'(BLOCKS_MAX);
        else
            r = v;
        return r;
    endfunction

endpackage

// ----- hdl/workgroup_head_block_swizzle.sv -----
// Top level: workgroup number to plain and swizzled head/block/chiplet mapping.
//
//  channel   | signals                                   | handshake
//  ----------+-------------------------------------------+---------------------------------
//  request   | group_number                              | transfer on start && !busy
//  result    | plain_head/block/chiplet, swizzled_*      | done high for one cycle
//  config    | psel penable pwrite paddr pwdata prdata   | APB, write on access, pready = 1
//
//  One transfer per cycle; busy is never raised.
//  The pipeline is a two-stage reciprocal multiply for the chiplet remainder, two
//  dividers of 4 quotient bits per stage in series (/ blocks, / heads-per-chiplet),
//  a multiply stage and the clamp/output stage.
//  Reset clears the valid chain and loads head_count = 8, blocks_in_head = 4.
//  The receiver cannot stall; results leave on the cycle they are ready.
module workgroup_head_block_swizzle #(
    parameter int CHIPLETS = swz_pkg::CHIPLETS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [swz_pkg::GROUP_W-1:0]     group_number,
    output logic                            done,
    output logic [swz_pkg::GROUP_W-1:0]     plain_head,
    output logic [swz_pkg::BLOCK_W-1:0]     plain_block,
    output logic [swz_pkg::CHIP_OUT_W-1:0]  plain_chiplet,
    output logic [swz_pkg::SHEAD_W-1:0]     swizzled_head_index,
    output logic [swz_pkg::BLOCK_W-1:0]     swizzled_block_index,
    output logic [swz_pkg::CHIP_OUT_W-1:0]  swizzled_chiplet,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [swz_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [swz_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [swz_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    localparam int GW        = swz_pkg::GROUP_W;
    localparam int HW        = swz_pkg::HEAD_CNT_W;
    localparam int BW        = swz_pkg::BLOCKS_W;
    localparam int KW        = swz_pkg::BLOCK_W;
    localparam int OW        = swz_pkg::CHIP_OUT_W;
    localparam int SW        = swz_pkg::SHEAD_W;
    localparam int DivStages = (GW + swz_pkg::DIV_STEPS - 1) / swz_pkg::DIV_STEPS;
    localparam int Lat       = 2 + 2 * DivStages + 2;
    localparam int ChipDenW  = $clog2(CHIPLETS + 1);
    localparam int ChipW     = (CHIPLETS > 1) ? $clog2(CHIPLETS) : 1;
    localparam int ModShift  = GW + $clog2(CHIPLETS);
    localparam int ModMulW   = GW + 2;
    localparam int ModMulVal = ((1 << ModShift) + CHIPLETS - 1) / CHIPLETS;
    localparam int ModProdW  = ModShift + GW;
    localparam int HpcShift  = HW + $clog2(CHIPLETS);
    localparam int HpcMulW   = HW + 2;
    localparam int HpcMulVal = ((1 << HpcShift) + CHIPLETS - 1) / CHIPLETS;
    localparam int HpcProdW  = HpcShift + HW;
    localparam int HpcRst    = (swz_pkg::HEADS_RST + CHIPLETS - 1) / CHIPLETS;
    localparam int ProdW     = ChipW + HW;
    localparam int SumW      = ProdW + 1;
    localparam int BTagW     = OW + KW + GW;

    localparam logic [ModMulW-1:0]  ModMul   = ModMulW'(ModMulVal);
    localparam logic [HpcMulW-1:0]  HpcMul   = HpcMulW'(HpcMulVal);
    localparam logic [GW-1:0]       ChipLast = GW'(CHIPLETS - 1);

    // configuration
    logic                 cfg_wr;
    logic [HW-1:0]        heads_raw_reg, heads_raw_next;
    logic [BW-1:0]        blocks_raw_reg, blocks_raw_next;
    logic [HW-1:0]        heads_eff_reg, heads_eff_next;
    logic [BW-1:0]        blocks_eff_reg, blocks_eff_next;
    logic [HW-1:0]        hpc_reg, hpc_next;
    logic [HW-1:0]        heads_wr;
    logic [HW:0]          hpc_x;
    logic [HpcProdW-1:0]  hpc_prod;
    swz_pkg::swz_reg_t    reg_sel;

    assign cfg_wr  = psel && penable && pwrite;
    assign reg_sel = swz_pkg::swz_reg_t'(paddr[2]);
    assign pready  = 1'b1;
    assign busy    = 1'b0;

    assign heads_wr = swz_pkg::clamp_heads(pwdata[HW-1:0]);
    assign hpc_x    = (HW + 1)'(heads_wr) + (HW + 1)'(CHIPLETS - 1);
    assign hpc_prod = HpcProdW'(hpc_x) * HpcProdW'(HpcMul);

    always_comb
    begin
        heads_raw_next  = heads_raw_reg;
        blocks_raw_next = blocks_raw_reg;
        heads_eff_next  = heads_eff_reg;
        blocks_eff_next = blocks_eff_reg;
        hpc_next        = hpc_reg;
        if (cfg_wr)
        begin
            case (reg_sel)
                swz_pkg::REG_HEAD_COUNT:
                begin
                    heads_raw_next = pwdata[HW-1:0];
                    heads_eff_next = heads_wr;
                    hpc_next       = hpc_prod[HpcShift +: HW];
                end
                swz_pkg::REG_BLOCKS_IN_HEAD:
                begin
                    blocks_raw_next = pwdata[BW-1:0];
                    blocks_eff_next = swz_pkg::clamp_blocks(pwdata[BW-1:0]);
                end
                default:
                begin
                    heads_raw_next = heads_raw_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            swz_pkg::REG_HEAD_COUNT:     prdata = swz_pkg::APB_DATA_W'(heads_raw_reg);
            swz_pkg::REG_BLOCKS_IN_HEAD: prdata = swz_pkg::APB_DATA_W'(blocks_raw_reg);
            default:                     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heads_raw_reg  <= HW'(swz_pkg::HEADS_RST);
            blocks_raw_reg <= BW'(swz_pkg::BLOCKS_RST);
            heads_eff_reg  <= HW'(swz_pkg::HEADS_RST);
            blocks_eff_reg <= BW'(swz_pkg::BLOCKS_RST);
            hpc_reg        <= HW'(HpcRst);
        end
        else
        begin
            heads_raw_reg  <= heads_raw_next;
            blocks_raw_reg <= blocks_raw_next;
            heads_eff_reg  <= heads_eff_next;
            blocks_eff_reg <= blocks_eff_next;
            hpc_reg        <= hpc_next;
        end
    end

    // chiplet remainder: reciprocal multiply, then multiply back and subtract
    logic                m1_valid_reg;
    logic [GW-1:0]       m1_group_reg;
    logic [ModProdW-1:0] m1_prod_reg, m1_prod_next;
    logic [GW-1:0]       m1_quo;
    logic                c_valid_reg;
    logic [GW-1:0]       c_group_reg;
    logic [ChipDenW-1:0] c_rem_reg, c_rem_next;

    assign m1_prod_next = ModProdW'(group_number) * ModProdW'(ModMul);
    assign m1_quo       = m1_prod_reg[ModShift +: GW];
    assign c_rem_next   = ChipDenW'(m1_group_reg - GW'(m1_quo * GW'(CHIPLETS)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg <= 1'b0;
            c_valid_reg  <= 1'b0;
        end
        else
        begin
            m1_valid_reg <= start && !busy;
            c_valid_reg  <= m1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m1_group_reg <= group_number;
        m1_prod_reg  <= m1_prod_next;
        c_group_reg  <= m1_group_reg;
        c_rem_reg    <= c_rem_next;
    end

    // divider chain
    logic                a_valid;
    logic [GW-1:0]       a_quo;
    logic [BW-1:0]       a_rem;
    logic [OW-1:0]       a_tag;
    logic                b_valid;
    logic [GW-1:0]       b_quo;
    logic [HW-1:0]       b_rem;
    logic [BTagW-1:0]    b_tag;

    swz_div #(
        .NUM_W (GW),
        .DEN_W (BW),
        .TAG_W (OW),
        .STEPS (swz_pkg::DIV_STEPS)
    ) u_div_block (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c_valid_reg),
        .in_num    (c_group_reg),
        .in_den    (blocks_eff_reg),
        .in_tag    (OW'(c_rem_reg)),
        .out_valid (a_valid),
        .out_quo   (a_quo),
        .out_rem   (a_rem),
        .out_tag   (a_tag)
    );

    swz_div #(
        .NUM_W (GW),
        .DEN_W (HW),
        .TAG_W (BTagW),
        .STEPS (swz_pkg::DIV_STEPS)
    ) u_div_head (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (a_valid),
        .in_num    (a_quo),
        .in_den    (hpc_reg),
        .in_tag    ({a_tag, a_rem[KW-1:0], a_quo}),
        .out_valid (b_valid),
        .out_quo   (b_quo),
        .out_rem   (b_rem),
        .out_tag   (b_tag)
    );

    // chiplet clamp and head base multiply
    logic             f1_valid_reg;
    logic [ChipW-1:0] chip_next, chip_reg;
    logic [ProdW-1:0] prod_next, prod_reg;
    logic [HW-1:0]    lhead_reg;
    logic [BTagW-1:0] f1_tag_reg;

    assign chip_next = (b_quo >= ChipLast) ? ChipLast[ChipW-1:0] : b_quo[ChipW-1:0];
    assign prod_next = ProdW'(chip_next) * ProdW'(hpc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f1_valid_reg <= 1'b0;
        else
            f1_valid_reg <= b_valid;
    end

    always_ff @(posedge clk)
    begin
        chip_reg   <= chip_next;
        prod_reg   <= prod_next;
        lhead_reg  <= b_rem;
        f1_tag_reg <= b_tag;
    end

    // head clamp and output register
    logic [SumW-1:0]  shead_sum;
    logic [HW-1:0]    head_last;
    logic [SW-1:0]    shead_next;
    logic             done_reg;
    logic [GW-1:0]    plain_head_reg;
    logic [KW-1:0]    block_reg;
    logic [OW-1:0]    plain_chiplet_reg;
    logic [SW-1:0]    shead_reg;
    logic [OW-1:0]    swz_chiplet_reg;

    assign shead_sum  = SumW'(prod_reg) + SumW'(lhead_reg);
    assign head_last  = heads_eff_reg - HW'(1);
    assign shead_next = (shead_sum > SumW'(head_last)) ? head_last[SW-1:0]
                                                       : shead_sum[SW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= f1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        plain_head_reg    <= f1_tag_reg[GW-1:0];
        block_reg         <= f1_tag_reg[GW +: KW];
        plain_chiplet_reg <= f1_tag_reg[GW + KW +: OW];
        shead_reg         <= shead_next;
        swz_chiplet_reg   <= OW'(chip_reg);
    end

    assign done                 = done_reg;
    assign plain_head           = plain_head_reg;
    assign plain_block          = block_reg;
    assign plain_chiplet        = plain_chiplet_reg;
    assign swizzled_head_index  = shead_reg;
    assign swizzled_block_index = block_reg;
    assign swizzled_chiplet     = swz_chiplet_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##Lat done)
        else $error("transfer did not complete after fixed latency");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, Lat))
        else $error("result without matching transfer");

    a_chip_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        f1_valid_reg |-> (chip_reg <= ChipLast[ChipW-1:0]))
        else $error("swizzled chiplet beyond last chiplet");

endmodule

// ----- hdl/swz_div.sv -----
// Pipelined restoring divider, STEPS quotient bits per stage, with a sideband tag.
module swz_div #(
    parameter int NUM_W = swz_pkg::GROUP_W,
    parameter int DEN_W = swz_pkg::BLOCKS_W,
    parameter int TAG_W = 1,
    parameter int STEPS = swz_pkg::DIV_STEPS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] in_num,
    input  logic [DEN_W-1:0] in_den,
    input  logic [TAG_W-1:0] in_tag,
    output logic             out_valid,
    output logic [NUM_W-1:0] out_quo,
    output logic [DEN_W-1:0] out_rem,
    output logic [TAG_W-1:0] out_tag
);

    localparam int NSTG = (NUM_W + STEPS - 1) / STEPS;

    logic             src_valid [NSTG];
    logic [NUM_W-1:0] src_num   [NSTG];
    logic [NUM_W-1:0] src_quo   [NSTG];
    logic [DEN_W-1:0] src_rem   [NSTG];
    logic [TAG_W-1:0] src_tag   [NSTG];

    logic [NUM_W-1:0] num_next  [NSTG];
    logic [NUM_W-1:0] quo_next  [NSTG];
    logic [DEN_W-1:0] rem_next  [NSTG];

    logic             valid_reg [NSTG];
    logic [NUM_W-1:0] num_reg   [NSTG];
    logic [NUM_W-1:0] quo_reg   [NSTG];
    logic [DEN_W-1:0] rem_reg   [NSTG];
    logic [TAG_W-1:0] tag_reg   [NSTG];

    for (genvar s = 0; s < NSTG; s++) begin : g_stg
        if (s == 0) begin : g_src
            assign src_valid[s] = in_valid;
            assign src_num[s]   = in_num;
            assign src_quo[s]   = '0;
            assign src_rem[s]   = '0;
            assign src_tag[s]   = in_tag;
        end else begin : g_src
            assign src_valid[s] = valid_reg[s-1];
            assign src_num[s]   = num_reg[s-1];
            assign src_quo[s]   = quo_reg[s-1];
            assign src_rem[s]   = rem_reg[s-1];
            assign src_tag[s]   = tag_reg[s-1];
        end

        always_comb
        begin : c_step
            logic [NUM_W-1:0] n;
            logic [NUM_W-1:0] q;
            logic [DEN_W-1:0] r;
            logic [DEN_W:0]   t;
            n = src_num[s];
            q = src_quo[s];
            r = src_rem[s];
            t = '0;
            for (int j = 0; j < STEPS; j++)
            begin
                if (s * STEPS + j < NUM_W)
                begin
                    t = {r, n[NUM_W-1]};
                    n = {n[NUM_W-2:0], 1'b0};
                    if (t >= {1'b0, in_den})
                    begin
                        t = t - {1'b0, in_den};
                        q = {q[NUM_W-2:0], 1'b1};
                    end
                    else
                    begin
                        q = {q[NUM_W-2:0], 1'b0};
                    end
                    r = t[DEN_W-1:0];
                end
            end
            num_next[s] = n;
            quo_next[s] = q;
            rem_next[s] = r;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[s] <= 1'b0;
            else
                valid_reg[s] <= src_valid[s];
        end

        always_ff @(posedge clk)
        begin
            num_reg[s] <= num_next[s];
            quo_reg[s] <= quo_next[s];
            rem_reg[s] <= rem_next[s];
            tag_reg[s] <= src_tag[s];
        end
    end

    assign out_valid = valid_reg[NSTG-1];
    assign out_quo   = quo_reg[NSTG-1];
    assign out_rem   = rem_reg[NSTG-1];
    assign out_tag   = tag_reg[NSTG-1];

endmodule
